### hw/rtl/gww_pkg.sv
// ----------------------------------------------------------------------------
// gww_pkg
// Shared constants and types of the greedy word wrapper.
// ----------------------------------------------------------------------------
`default_nettype none

package gww_pkg;

  localparam int unsigned MAX_WIDTH = 31;
  localparam int unsigned ROW_DEPTH = 32;
  localparam int unsigned PTR_W     = $clog2(ROW_DEPTH);
  localparam int unsigned FILL_W    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CNT_W     = 16;

  localparam logic [7:0]       CH_NEWLINE = 8'd10;
  localparam logic [7:0]       CH_SPACE   = 8'd32;
  localparam logic [CNT_W-1:0] COUNT_MAX  = '1;

  // Row store write port, front to back.
  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
    logic [7:0]       data;
  } wr_t;

  // One drain request: head_len bytes, optional skipped byte, optional
  // newline, then tail_len bytes, all tagged with the line total.
  typedef struct packed {
    logic [FILL_W-1:0] head_len;
    logic              skip;
    logic              newline;
    logic [FILL_W-1:0] tail_len;
    logic [CNT_W-1:0]  total;
  } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/greedy_word_wrapper_unit.sv
// ----------------------------------------------------------------------------
// greedy_word_wrapper_unit
// Wraps a byte stream to a configured line width with greedy word breaks.
// ----------------------------------------------------------------------------
// A finished row's first result passes the request queue, the drain state,
// the row store read and the output register; an empty row's newline skips
// the read. Throughput: one request a cycle into the open row; a result byte
// passes RUN and DATA, an inserted newline or dropped space RUN alone.
// Requests stall only when the request queue is full or the row store slot
// is still waiting to be drained. Reset: row empty, line total 1, width 31.
`default_nettype none

module greedy_word_wrapper_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [4:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_char_i,
  input  wire logic        end_of_text_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_char_o,
  output logic             run_last_o,
  output logic [15:0]      line_total_o
);

  gww_pkg::cmd_t push_cmd, pop_cmd;
  gww_pkg::wr_t  wr;
  logic          q_full, q_empty, push, pop, rel;

  gww_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_char_i     (in_char_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (push_cmd),
    .wr_o          (wr),
    .release_i     (rel)
  );

  gww_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .cmd_o   (pop_cmd),
    .empty_o (q_empty)
  );

  gww_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .q_empty_i    (q_empty),
    .cmd_i        (pop_cmd),
    .pop_o        (pop),
    .release_o    (rel),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_char_o   (out_char_o),
    .run_last_o   (run_last_o),
    .line_total_o (line_total_o)
  );

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("request pushed into full queue");

  a_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("request popped from empty queue");

  a_total_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (line_total_o != 16'd0))
    else $error("line total zero on result");

  a_wr_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (in_valid_i && in_ready_o))
    else $error("row store written without accepted request");

endmodule

`default_nettype wire

### hw/rtl/gww_front.sv
// ----------------------------------------------------------------------------
// gww_front
// Accepts characters, tracks the open row and issues drain requests.
// ----------------------------------------------------------------------------
`default_nettype none

module gww_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [4:0]                   cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [7:0]                   in_char_i,
  input  wire logic                         end_of_text_i,
  input  wire logic                         q_full_i,
  output logic                              push_o,
  output gww_pkg::cmd_t                     cmd_o,
  output gww_pkg::wr_t                      wr_o,
  input  wire logic                         release_i
);

  localparam int unsigned FW = gww_pkg::FILL_W;
  localparam int unsigned PW = gww_pkg::PTR_W;
  localparam int unsigned OW = PW + 1;

  logic [4:0]                  width_q;
  logic [FW-1:0]               fill_q, fill_d;
  logic [FW-1:0]               lsp_q, lsp_d;
  logic                        sp_q, sp_d;
  logic [PW-1:0]               head_q, head_d;
  logic [OW-1:0]               pend_q, pend_d;
  logic [gww_pkg::CNT_W-1:0]   cnt_q, cnt_d;

  logic [FW-1:0] w_eff;
  logic [FW-1:0] head_len, tail_len, fill_m;
  logic [PW-1:0] head_m;
  logic          skip, nl, inc, wr_en, hazard, accept;
  logic [OW-1:0] consumed;

  always_comb begin
    if (width_q == 5'd0) begin
      w_eff = FW'(1);
    end else if (32'(width_q) > gww_pkg::MAX_WIDTH) begin
      w_eff = FW'(gww_pkg::MAX_WIDTH);
    end else begin
      w_eff = FW'(width_q);
    end
  end

  always_comb begin
    head_len = '0;
    tail_len = '0;
    skip     = 1'b0;
    nl       = 1'b0;
    inc      = 1'b0;
    wr_en    = 1'b0;
    fill_m   = fill_q;
    head_m   = head_q;
    lsp_d    = lsp_q;
    sp_d     = sp_q;
    if (in_char_i == 8'd0) begin
      // ignored
    end else if (in_char_i == gww_pkg::CH_NEWLINE) begin
      head_len = fill_q;
      nl       = 1'b1;
      inc      = 1'b1;
      head_m   = head_q + PW'(fill_q);
      fill_m   = '0;
      lsp_d    = '0;
      sp_d     = 1'b0;
    end else if (fill_q < w_eff) begin
      wr_en  = 1'b1;
      fill_m = fill_q + FW'(1);
      if (in_char_i == gww_pkg::CH_SPACE) begin
        lsp_d = fill_q;
        sp_d  = 1'b1;
      end
    end else if (in_char_i == gww_pkg::CH_SPACE) begin
      head_len = fill_q;
      nl       = 1'b1;
      inc      = 1'b1;
      head_m   = head_q + PW'(fill_q);
      fill_m   = '0;
      lsp_d    = '0;
      sp_d     = 1'b0;
    end else if (sp_q) begin
      // word wrap: drop the last space, keep the word after it
      head_len = lsp_q;
      skip     = 1'b1;
      nl       = 1'b1;
      inc      = 1'b1;
      wr_en    = 1'b1;
      head_m   = head_q + PW'(lsp_q) + PW'(1);
      fill_m   = fill_q - lsp_q;
      lsp_d    = '0;
      sp_d     = 1'b0;
    end else begin
      // hard break
      head_len = fill_q;
      nl       = 1'b1;
      inc      = 1'b1;
      wr_en    = 1'b1;
      head_m   = head_q + PW'(fill_q);
      fill_m   = FW'(1);
      lsp_d    = '0;
      sp_d     = 1'b0;
    end

    head_d = head_m;
    fill_d = fill_m;
    if (end_of_text_i) begin
      tail_len = fill_m;
      head_d   = head_m + PW'(fill_m);
      fill_d   = '0;
      lsp_d    = '0;
      sp_d     = 1'b0;
    end
  end

  assign consumed = OW'(head_len) + OW'(skip) + OW'(tail_len);
  // the write slot must not hold a byte still waiting to be drained
  assign hazard     = wr_en && ((OW'(fill_q) + pend_q) == OW'(gww_pkg::ROW_DEPTH));
  assign in_ready_o = !q_full_i && !hazard;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && ((head_len != '0) || nl || (tail_len != '0));
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cnt_d = cnt_q;
    if (accept && inc && (cnt_q != gww_pkg::COUNT_MAX)) begin
      cnt_d = cnt_q + gww_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    pend_d = pend_q - OW'(release_i);
    if (push_o) begin
      pend_d = pend_d + consumed;
    end
  end

  always_comb begin
    cmd_o.head_len = head_len;
    cmd_o.skip     = skip;
    cmd_o.newline  = nl;
    cmd_o.tail_len = tail_len;
    cmd_o.total    = cnt_d;
    wr_o.en        = accept && wr_en;
    wr_o.addr      = head_q + PW'(fill_q);
    wr_o.data      = in_char_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 5'd31;
      fill_q  <= '0;
      lsp_q   <= '0;
      sp_q    <= 1'b0;
      head_q  <= '0;
      pend_q  <= '0;
      cnt_q   <= gww_pkg::CNT_W'(1);
    end else begin
      if (cfg_valid_i) begin
        width_q <= cfg_data_i;
      end
      if (accept) begin
        fill_q <= fill_d;
        lsp_q  <= lsp_d;
        sp_q   <= sp_d;
        head_q <= head_d;
        cnt_q  <= cnt_d;
      end
      pend_q <= pend_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/gww_cmd_fifo.sv
// ----------------------------------------------------------------------------
// gww_cmd_fifo
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module gww_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire gww_pkg::cmd_t cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output gww_pkg::cmd_t      cmd_o,
  output logic               empty_o
);

  gww_pkg::cmd_t slot_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign cmd_o   = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/gww_back.sv
// ----------------------------------------------------------------------------
// gww_back
// Holds the row store and drains requests into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gww_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire gww_pkg::wr_t                wr_i,
  input  wire logic                        q_empty_i,
  input  wire gww_pkg::cmd_t               cmd_i,
  output logic                             pop_o,
  output logic                             release_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [7:0]                       out_char_o,
  output logic                             run_last_o,
  output logic [gww_pkg::CNT_W-1:0]        line_total_o
);

  localparam int unsigned FW = gww_pkg::FILL_W;
  localparam int unsigned PW = gww_pkg::PTR_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;

  logic [7:0] mem [gww_pkg::ROW_DEPTH];

  logic [1:0]                state_q, state_d;
  logic [FW-1:0]             head_q, head_d, tail_q, tail_d;
  logic                      skip_q, skip_d, nl_q, nl_d;
  logic [gww_pkg::CNT_W-1:0] total_q;
  logic [PW-1:0]             rptr_q, rptr_d;
  logic [7:0]                rd_q;
  logic                      rd_last_q, rd_last_d;
  logic                      rd_en;
  logic                      out_free, load;
  logic [7:0]                load_char;
  logic                      load_last;

  logic                      ov_q;
  logic [7:0]                oc_q;
  logic                      ol_q;
  logic [gww_pkg::CNT_W-1:0] ot_q;

  assign out_free = !ov_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    skip_d    = skip_q;
    nl_d      = nl_q;
    rptr_d    = rptr_q;
    rd_last_d = rd_last_q;
    rd_en     = 1'b0;
    release_o = 1'b0;
    pop_o     = 1'b0;
    load      = 1'b0;
    load_char = rd_q;
    load_last = rd_last_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          head_d  = cmd_i.head_len;
          tail_d  = cmd_i.tail_len;
          skip_d  = cmd_i.skip;
          nl_d    = cmd_i.newline;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (head_q != '0) begin
          rd_en     = 1'b1;
          release_o = 1'b1;
          rptr_d    = rptr_q + PW'(1);
          head_d    = head_q - FW'(1);
          rd_last_d = (head_q == FW'(1)) && !nl_q && (tail_q == '0);
          state_d   = ST_DATA;
        end else if (skip_q) begin
          release_o = 1'b1;
          rptr_d    = rptr_q + PW'(1);
          skip_d    = 1'b0;
        end else if (nl_q) begin
          if (out_free) begin
            load      = 1'b1;
            load_char = gww_pkg::CH_NEWLINE;
            load_last = tail_q == '0;
            nl_d      = 1'b0;
          end
        end else if (tail_q != '0) begin
          rd_en     = 1'b1;
          release_o = 1'b1;
          rptr_d    = rptr_q + PW'(1);
          tail_d    = tail_q - FW'(1);
          rd_last_d = tail_q == FW'(1);
          state_d   = ST_DATA;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DATA: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = ST_RUN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en) begin
      rd_q <= mem[rptr_q];
    end
    if (pop_o) begin
      total_q <= cmd_i.total;
    end
    if (load) begin
      oc_q <= load_char;
      ol_q <= load_last;
      ot_q <= total_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      skip_q    <= 1'b0;
      nl_q      <= 1'b0;
      rptr_q    <= '0;
      rd_last_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      skip_q    <= skip_d;
      nl_q      <= nl_d;
      rptr_q    <= rptr_d;
      rd_last_q <= rd_last_d;
      if (load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = ov_q;
  assign out_char_o   = oc_q;
  assign run_last_o   = ol_q;
  assign line_total_o = ot_q;

endmodule

`default_nettype wire

### bench/gww_wrap_check.sv
// ----------------------------------------------------------------------------
// gww_wrap_check
// Watches the width, text and wrapped-output channels of the word wrapper,
// predicts every wrapped byte with its own row model and compares each
// output request field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gww_wrap_check
  import gww_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [4:0]        cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        in_char_i,
  input  logic              end_of_text_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [7:0]        out_char_i,
  input  logic              run_last_i,
  input  logic [15:0]       line_total_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       bytes_seen_o
);

  localparam logic [7:0] CH_NUL = 8'd0;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [7:0]       ch;
    logic             last;
    logic [CNT_W-1:0] total;
  } wrap_byte_t;

  wrap_byte_t       wrapped_q [$];
  logic [7:0]       step_bytes [$];
  logic [7:0]       row_buf [ROW_DEPTH];
  int unsigned      row_len;
  int unsigned      gap_pos;
  logic             gap_seen;
  logic [CNT_W-1:0] lines;
  logic [4:0]       width_q;

  function automatic void emit_row(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n && i < ROW_DEPTH; i++) begin
      step_bytes.push_back(row_buf[i]);
    end
  endfunction

  function automatic void count_line();
    if (lines != COUNT_MAX) begin
      lines++;
    end
  endfunction

  function automatic void clear_row();
    row_len  = 0;
    gap_pos  = 0;
    gap_seen = 1'b0;
  endfunction

  function automatic void wrap_step(input logic [7:0] c, input logic eot);
    int unsigned w;
    int unsigned i;
    int unsigned j;
    w = (width_q == 0) ? 1 : width_q;
    if (w > MAX_WIDTH) begin
      w = MAX_WIDTH;
    end
    step_bytes.delete();

    if (c == CH_NUL) begin
    end else if (c == CH_NEWLINE) begin
      emit_row(row_len);
      step_bytes.push_back(CH_NEWLINE);
      count_line();
      clear_row();
    end else if (row_len < w) begin
      if (c == CH_SPACE) begin
        gap_pos  = row_len;
        gap_seen = 1'b1;
      end
      row_buf[row_len] = c;
      row_len++;
    end else if (c == CH_SPACE) begin
      emit_row(row_len);
      step_bytes.push_back(CH_NEWLINE);
      count_line();
      clear_row();
    end else if (gap_seen) begin
      // break at the last space, carry the partial word over
      emit_row(gap_pos);
      step_bytes.push_back(CH_NEWLINE);
      count_line();
      j = 0;
      for (i = gap_pos + 1; i < row_len; i++) begin
        row_buf[j] = row_buf[i];
        j++;
      end
      row_buf[j] = c;
      row_len  = j + 1;
      gap_seen = 1'b0;
      gap_pos  = 0;
    end else begin
      // hard break before the overflowing byte
      emit_row(row_len);
      step_bytes.push_back(CH_NEWLINE);
      count_line();
      row_buf[0] = c;
      row_len  = 1;
      gap_seen = 1'b0;
      gap_pos  = 0;
    end

    if (eot) begin
      emit_row(row_len);
      clear_row();
    end

    for (i = 0; i < step_bytes.size(); i++) begin
      wrapped_q.push_back('{ch: step_bytes[i], last: (i == step_bytes.size() - 1),
                            total: lines});
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wrap_byte_t want;
    if (!rst_ni) begin
      wrapped_q.delete();
      clear_row();
      lines        = 1;
      width_q      = 5'(MAX_WIDTH);
      fail_count_o = 0;
      bytes_seen_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        width_q = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        wrap_step(in_char_i, end_of_text_i);
      end
      if (out_valid_i && out_ready_i) begin
        bytes_seen_o++;
        if (wrapped_q.size() == 0) begin
          if (fail_count_o < REPORT_MAX) begin
            $display("%0t: stray output request char %02h last %0b total %0d",
                     $realtime, out_char_i, run_last_i, line_total_i);
          end
          fail_count_o++;
        end else begin
          want = wrapped_q.pop_front();
          if (out_char_i !== want.ch || run_last_i !== want.last ||
              line_total_i !== want.total) begin
            if (fail_count_o < REPORT_MAX) begin
              $display("%0t: mismatch exp char %02h last %0b total %0d, got char %02h last %0b total %0d",
                       $realtime, want.ch, want.last, want.total,
                       out_char_i, run_last_i, line_total_i);
            end
            fail_count_o++;
          end
        end
      end
      pending_o = wrapped_q.size();
    end
  end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives text through the word wrapper at a range of line widths: a short
// hand-picked run of edge cases, then random prose, long unbroken words and
// stray bytes, with bursty input, a stalling output and long output
// hold-offs. Checking is done by gww_wrap_check.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import gww_pkg::*;

  localparam logic [7:0]  CH_NUL        = 8'd0;
  localparam int unsigned TEXT_REQS     = 57;
  localparam int unsigned N_PHASES      = 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 6;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data      = '0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char       = 8'h61;
  logic        end_of_text   = 1'b0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [7:0]  out_char;
  logic        run_last;
  logic [15:0] line_total;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned bytes_seen;
  int unsigned n_reqs        = 0;
  int unsigned n_widths      = 0;
  int unsigned n_holds       = 0;
  int unsigned burst_left    = 0;
  logic        hold_req      = 1'b0;

  greedy_word_wrapper_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .in_char_i     (in_char),
    .end_of_text_i (end_of_text),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_char_o    (out_char),
    .run_last_o    (run_last),
    .line_total_o  (line_total)
  );

  gww_wrap_check wrap_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_char_i     (in_char),
    .end_of_text_i (end_of_text),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_char_i    (out_char),
    .run_last_i    (run_last),
    .line_total_i  (line_total),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .bytes_seen_o  (bytes_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(30_000_000);
    $display("tb failed");
    $finish;
  end

  function automatic logic [7:0] pick_letter();
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] word_char();
    if ($urandom_range(0, 9) == 0) begin
      return 8'($urandom_range(33, 126));
    end
    return pick_letter();
  endfunction

  function automatic logic [7:0] eot_char();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_NEWLINE;
      2:       return 8'($urandom_range(1, 255));
      default: return pick_letter();
    endcase
  endfunction

  task automatic send_req(input logic [7:0] c, input logic eot);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
    end
    in_valid    <= 1'b1;
    in_char     <= c;
    end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (c != CH_NUL || eot) begin
      n_reqs++;
    end
  endtask

  // Only once every predicted byte has drained and the row logic has settled.
  task automatic set_width(input int unsigned w);
    in_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= 5'(w);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_widths++;
  endtask

  task automatic write_text(input int unsigned budget);
    int unsigned start;
    int unsigned r;
    int unsigned k;
    int unsigned len;
    start = n_reqs;
    while (n_reqs - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        r   = $urandom_range(0, 9);
        len = (r < 7) ? $urandom_range(1, 8) : (r < 9) ? $urandom_range(9, 20)
                                                       : $urandom_range(21, 40);
        for (k = 0; k < len; k++) begin
          send_req(word_char(), 1'b0);
        end
        send_req(CH_SPACE, 1'b0);
        if ($urandom_range(0, 4) == 0) begin
          send_req(CH_SPACE, 1'b0);
        end
      end else if (r < 70) begin
        send_req(CH_NEWLINE, 1'b0);
      end else if (r < 82) begin
        send_req(8'($urandom_range(1, 255)), 1'b0);
      end else if (r < 88) begin
        send_req(eot_char(), 1'b1);
      end else begin
        len = $urandom_range(25, 45);
        for (k = 0; k < len; k++) begin
          send_req(pick_letter(), 1'b0);
        end
      end
    end
  endtask

  // output side: stall patterns, plus long hold-offs on request
  initial begin
    int unsigned mode;
    int unsigned seg;
    int unsigned i;
    logic [15:0] pat;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        n_holds++;
      end else begin
        mode = $urandom_range(0, 3);
        seg  = $urandom_range(1, 48);
        pat  = 16'($urandom) | 16'h0001;
        for (i = 0; i < seg; i++) begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= pat[i % 16];
            default: out_ready <= (i % 4 == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    int unsigned ph;
    int unsigned w;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // width zero behaves as one: hard break, overflowing space, ignored nul
    set_width(0);
    send_req("a", 1'b0);
    send_req("b", 1'b0);
    send_req(CH_SPACE, 1'b0);
    send_req(CH_NUL, 1'b0);
    send_req("c", 1'b1);

    // byte extremes, newline, nul still flushing at end of text
    set_width(MAX_WIDTH);
    send_req(8'hff, 1'b0);
    send_req(8'h01, 1'b0);
    send_req(CH_SPACE, 1'b0);
    send_req(CH_NEWLINE, 1'b0);
    send_req("x", 1'b0);
    send_req(CH_NUL, 1'b1);

    // row left open, then width lowered under it
    send_req("a", 1'b0);
    send_req("b", 1'b0);
    send_req(CH_SPACE, 1'b0);
    send_req("c", 1'b0);
    send_req("d", 1'b0);
    send_req("e", 1'b0);
    send_req("f", 1'b0);
    send_req("g", 1'b0);
    send_req("h", 1'b0);
    send_req("i", 1'b0);
    send_req("j", 1'b0);
    set_width(4);
    send_req("k", 1'b0);
    send_req("l", 1'b0);
    send_req("m", 1'b1);

    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0, 6:    w = 1;
        1, 5:    w = MAX_WIDTH;
        3:       w = 2;
        default: w = $urandom_range(3, 30);
      endcase
      set_width(w);
      if (ph == 2 || ph == 5) begin
        hold_req = 1'b1;
      end
      write_text(TEXT_REQS);
      if ($urandom_range(0, 2) != 0) begin
        send_req(pick_letter(), 1'b1);
      end
    end
    send_req(pick_letter(), 1'b1);

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d text requests over %0d width settings, %0d output bytes.",
             n_reqs, n_widths, bytes_seen);
    $display("Long output hold-offs: %0d; failures counted: %0d.", n_holds, fail_count);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
